/* design/kea_pkg.sv */
// Package for the Kruskal edge acceptor: sizes, codes, memory word and FSM states.
package kea_pkg;

    // Node store geometry.
    localparam int NODES  = 2048;
    localparam int NODE_W = $clog2(NODES);

    // Field widths.
    localparam int WEIGHT_W = 62;
    localparam int TOTAL_W  = 63;
    localparam int COUNT_W  = 12;
    localparam int RANK_W   = 4;

    // Saturation limits and reset values.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [RANK_W-1:0]  RANK_MAX  = {RANK_W{1'b1}};
    localparam logic [RANK_W-1:0]  RANK_INIT = RANK_W'(1);

    // Input operation codes.
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    // Configuration register indexes (paddr[2] selects the register).
    localparam logic REG_VIRTUAL_NODE = 1'b0;

    // One entry of the disjoint-set store.
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [NODE_W-1:0] parent;
    } node_word_t;

    localparam int WORD_W = RANK_W + NODE_W;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FIND_START,
        ST_FIND_HOP,
        ST_COMP_START,
        ST_COMP_HOP,
        ST_UNION_LO,
        ST_UNION_HI,
        ST_RESULT
    } state_t;

endpackage

/* design/kea_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module kea_ram #(
    parameter int WIDTH  = 15,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/kruskal_edge_acceptor.sv */
// Top level of the Kruskal edge acceptor: sequencer around the disjoint-set RAM.
//
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid / in_stall      op, weight, node_a, node_b
//  out      output     out_valid / out_stall    accepted, total_cost, station_count, link_count
//  cfg      input      APB psel/penable/pready  virtual_node at byte address 0
//
// An edge item finds the root of node_a, compresses its path, then does the same for node_b,
// links the two roots and, when the union raises a rank, writes the grown rank as well;
// each hop is one read of the single parent/rank RAM, and the path compression walks
// the same hops again.
// A clear item rewrites one RAM row per cycle until all 2048 rows are rewritten.
// After reset the same clearing pass over all 2048 rows runs with in_stall high and no result.
// A finished result waits in the output register while out_stall is high; the next
// item is taken meanwhile and holds in the result state until the register frees.
module kruskal_edge_acceptor (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input channel.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [kea_pkg::WEIGHT_W-1:0]   weight,
    input  logic [kea_pkg::NODE_W-1:0]     node_a,
    input  logic [kea_pkg::NODE_W-1:0]     node_b,
    // Output channel.
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic [kea_pkg::TOTAL_W-1:0]    total_cost,
    output logic [kea_pkg::COUNT_W-1:0]    station_count,
    output logic [kea_pkg::COUNT_W-1:0]    link_count,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    kea_pkg::state_t state_reg, state_next;

    logic                         side_reg, side_next;
    logic                         clr_item_reg, clr_item_next;
    logic [kea_pkg::NODE_W-1:0]   cnt_reg, cnt_next;
    logic [kea_pkg::NODE_W-1:0]   cur_reg, cur_next;

    logic [kea_pkg::WEIGHT_W-1:0] weight_reg, weight_next;
    logic [kea_pkg::NODE_W-1:0]   node_a_reg, node_a_next;
    logic [kea_pkg::NODE_W-1:0]   node_b_reg, node_b_next;

    logic [kea_pkg::NODE_W-1:0]   root_a_reg, root_a_next;
    logic [kea_pkg::NODE_W-1:0]   root_b_reg, root_b_next;
    logic [kea_pkg::RANK_W-1:0]   rank_a_reg, rank_a_next;
    logic [kea_pkg::RANK_W-1:0]   rank_b_reg, rank_b_next;
    logic                         acc_reg, acc_next;

    logic [kea_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [kea_pkg::COUNT_W-1:0]  stations_reg, stations_next;
    logic [kea_pkg::COUNT_W-1:0]  links_reg, links_next;
    logic [kea_pkg::NODE_W-1:0]   vnode_reg;

    logic                         out_valid_reg, out_valid_next;
    logic                         accepted_reg;
    logic [kea_pkg::TOTAL_W-1:0]  total_cost_reg;
    logic [kea_pkg::COUNT_W-1:0]  station_count_reg;
    logic [kea_pkg::COUNT_W-1:0]  link_count_reg;

    logic                         mem_we, mem_re;
    logic [kea_pkg::NODE_W-1:0]   mem_waddr, mem_raddr;
    kea_pkg::node_word_t          mem_wdata, mem_rdata;

    logic                         in_accept, out_load, range_ok;
    logic                         roots_differ, rank_bump;
    logic [kea_pkg::NODE_W-1:0]   node_sel, root_sel;
    logic [kea_pkg::TOTAL_W:0]    sum_wide;

    // Parent and rank share one RAM word per node.
    kea_ram #(
        .WIDTH (kea_pkg::WORD_W),
        .DEPTH (kea_pkg::NODES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handshake and shared decode.
    assign in_stall  = (state_reg != kea_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == kea_pkg::ST_RESULT) && (!out_valid_reg || !out_stall);
    assign range_ok  = ((kea_pkg::NODE_W+1)'(node_a) < (kea_pkg::NODE_W+1)'(kea_pkg::NODES))
                    && ((kea_pkg::NODE_W+1)'(node_b) < (kea_pkg::NODE_W+1)'(kea_pkg::NODES));
    assign node_sel  = side_reg ? node_b_reg : node_a_reg;
    assign root_sel  = side_reg ? root_b_reg : root_a_reg;
    assign roots_differ = (root_a_reg != root_b_reg);
    assign rank_bump = roots_differ && (rank_a_reg == rank_b_reg)
                    && (rank_b_reg < kea_pkg::RANK_MAX);
    assign sum_wide  = {1'b0, total_reg} + (kea_pkg::TOTAL_W+1)'(weight_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kea_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == kea_pkg::OP_CLEAR)
                    begin
                        state_next = kea_pkg::ST_CLEAR;
                    end
                    else if (range_ok)
                    begin
                        state_next = kea_pkg::ST_FIND_START;
                    end
                    else
                    begin
                        state_next = kea_pkg::ST_RESULT;
                    end
                end
            end
            kea_pkg::ST_CLEAR:
            begin
                if (cnt_reg == kea_pkg::NODE_W'(kea_pkg::NODES - 1))
                begin
                    state_next = clr_item_reg ? kea_pkg::ST_RESULT : kea_pkg::ST_IDLE;
                end
            end
            kea_pkg::ST_FIND_START:
            begin
                state_next = kea_pkg::ST_FIND_HOP;
            end
            kea_pkg::ST_FIND_HOP:
            begin
                if (mem_rdata.parent == cur_reg)
                begin
                    state_next = kea_pkg::ST_COMP_START;
                end
            end
            kea_pkg::ST_COMP_START:
            begin
                if (node_sel == root_sel)
                begin
                    state_next = side_reg ? kea_pkg::ST_UNION_LO : kea_pkg::ST_FIND_START;
                end
                else
                begin
                    state_next = kea_pkg::ST_COMP_HOP;
                end
            end
            kea_pkg::ST_COMP_HOP:
            begin
                if (mem_rdata.parent == root_sel)
                begin
                    state_next = side_reg ? kea_pkg::ST_UNION_LO : kea_pkg::ST_FIND_START;
                end
            end
            kea_pkg::ST_UNION_LO:
            begin
                state_next = rank_bump ? kea_pkg::ST_UNION_HI : kea_pkg::ST_RESULT;
            end
            kea_pkg::ST_UNION_HI:
            begin
                state_next = kea_pkg::ST_RESULT;
            end
            kea_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = kea_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kea_pkg::ST_IDLE;
            end
        endcase
    end

    // RAM controls and datapath next values.
    always_comb
    begin
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = cur_reg;
        mem_raddr     = cur_reg;
        mem_wdata     = '0;
        side_next     = side_reg;
        clr_item_next = clr_item_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        weight_next   = weight_reg;
        node_a_next   = node_a_reg;
        node_b_next   = node_b_reg;
        root_a_next   = root_a_reg;
        root_b_next   = root_b_reg;
        rank_a_next   = rank_a_reg;
        rank_b_next   = rank_b_reg;
        acc_next      = acc_reg;
        total_next    = total_reg;
        stations_next = stations_reg;
        links_next    = links_reg;
        case (state_reg)
            kea_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    weight_next   = weight;
                    node_a_next   = node_a;
                    node_b_next   = node_b;
                    side_next     = 1'b0;
                    acc_next      = 1'b0;
                    cnt_next      = '0;
                    clr_item_next = 1'b1;
                    if (op == kea_pkg::OP_CLEAR)
                    begin
                        total_next    = '0;
                        stations_next = '0;
                        links_next    = '0;
                    end
                end
            end
            kea_pkg::ST_CLEAR:
            begin
                // Each node becomes its own root with rank one.
                mem_we           = 1'b1;
                mem_waddr        = cnt_reg;
                mem_wdata.rank   = kea_pkg::RANK_INIT;
                mem_wdata.parent = cnt_reg;
                cnt_next         = cnt_reg + kea_pkg::NODE_W'(1);
            end
            kea_pkg::ST_FIND_START:
            begin
                mem_re    = 1'b1;
                mem_raddr = node_sel;
                cur_next  = node_sel;
            end
            kea_pkg::ST_FIND_HOP:
            begin
                // Follow parent links until an entry points at itself.
                if (mem_rdata.parent == cur_reg)
                begin
                    if (side_reg)
                    begin
                        root_b_next = cur_reg;
                        rank_b_next = mem_rdata.rank;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        rank_a_next = mem_rdata.rank;
                    end
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = mem_rdata.parent;
                    cur_next  = mem_rdata.parent;
                end
            end
            kea_pkg::ST_COMP_START:
            begin
                if (node_sel == root_sel)
                begin
                    side_next = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = node_sel;
                    cur_next  = node_sel;
                end
            end
            kea_pkg::ST_COMP_HOP:
            begin
                // Point the current node at the root and fetch the next one on the path.
                mem_we           = 1'b1;
                mem_waddr        = cur_reg;
                mem_wdata.rank   = mem_rdata.rank;
                mem_wdata.parent = root_sel;
                if (mem_rdata.parent == root_sel)
                begin
                    side_next = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = mem_rdata.parent;
                    cur_next  = mem_rdata.parent;
                end
            end
            kea_pkg::ST_UNION_LO:
            begin
                // Link the lower-ranked root under the other and update the totals.
                if (roots_differ)
                begin
                    acc_next = 1'b1;
                    mem_we   = 1'b1;
                    if (rank_a_reg > rank_b_reg)
                    begin
                        mem_waddr        = root_b_reg;
                        mem_wdata.rank   = rank_b_reg;
                        mem_wdata.parent = root_a_reg;
                    end
                    else
                    begin
                        mem_waddr        = root_a_reg;
                        mem_wdata.rank   = rank_a_reg;
                        mem_wdata.parent = root_b_reg;
                    end
                    if (sum_wide > {1'b0, kea_pkg::TOTAL_MAX})
                    begin
                        total_next = kea_pkg::TOTAL_MAX;
                    end
                    else
                    begin
                        total_next = sum_wide[kea_pkg::TOTAL_W-1:0];
                    end
                    if ((node_a_reg == vnode_reg) || (node_b_reg == vnode_reg))
                    begin
                        if (stations_reg != kea_pkg::COUNT_MAX)
                        begin
                            stations_next = stations_reg + kea_pkg::COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (links_reg != kea_pkg::COUNT_MAX)
                        begin
                            links_next = links_reg + kea_pkg::COUNT_W'(1);
                        end
                    end
                end
            end
            kea_pkg::ST_UNION_HI:
            begin
                // Equal ranks: the surviving root grows by one.
                mem_we           = 1'b1;
                mem_waddr        = root_b_reg;
                mem_wdata.rank   = rank_b_reg + kea_pkg::RANK_W'(1);
                mem_wdata.parent = root_b_reg;
            end
            kea_pkg::ST_RESULT:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Output register: holds a result while the consumer stalls.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Control state and running totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kea_pkg::ST_CLEAR;
            side_reg      <= 1'b0;
            clr_item_reg  <= 1'b0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            stations_reg  <= '0;
            links_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            clr_item_reg  <= clr_item_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            stations_reg  <= stations_next;
            links_reg     <= links_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload and traversal registers.
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        weight_reg <= weight_next;
        node_a_reg <= node_a_next;
        node_b_reg <= node_b_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
        acc_reg    <= acc_next;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            accepted_reg      <= acc_reg;
            total_cost_reg    <= total_reg;
            station_count_reg <= stations_reg;
            link_count_reg    <= links_reg;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vnode_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == kea_pkg::REG_VIRTUAL_NODE))
        begin
            vnode_reg <= pwdata[kea_pkg::NODE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == kea_pkg::REG_VIRTUAL_NODE) ? 32'(vnode_reg) : 32'd0;

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign total_cost    = total_cost_reg;
    assign station_count = station_count_reg;
    assign link_count    = link_count_reg;

`ifndef SYNTHESIS
    // A compression write never hits the row being fetched in the same cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("RAM read and write address collide");

    // A hop always consumes data that was read in the previous cycle.
    a_hop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == kea_pkg::ST_FIND_HOP) || (state_reg == kea_pkg::ST_COMP_HOP))
        |-> $past(mem_re))
        else $error("hop without a pending RAM read");

    // The running total never falls during a union.
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kea_pkg::ST_UNION_LO) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased");
`endif

endmodule

/* tb/tb_kruskal_edge_acceptor.sv */
// Self-checking testbench for the Kruskal edge acceptor with a disjoint-set predictor.
`timescale 1ns / 1ps

module tb_kruskal_edge_acceptor;

    localparam logic [kea_pkg::WEIGHT_W-1:0] WEIGHT_MAX  = {kea_pkg::WEIGHT_W{1'b1}};
    localparam logic [kea_pkg::NODE_W-1:0]   LAST_NODE   =
        kea_pkg::NODE_W'(kea_pkg::NODES - 1);
    localparam logic [2:0]                   VN_ADDR     =
        {kea_pkg::REG_VIRTUAL_NODE, 2'b00};
    localparam int                           QUIET_LIMIT = 20000;
    localparam int                           RAND_PHASES = 10;
    localparam int                           PHASE_ITEMS = 170;

    // One expected output beat.
    typedef struct {
        logic                        accepted;
        logic [kea_pkg::TOTAL_W-1:0] total_cost;
        logic [kea_pkg::COUNT_W-1:0] station_count;
        logic [kea_pkg::COUNT_W-1:0] link_count;
    } mst_result_t;

    // Tracks the spanning forest and holds the output beats still owed by the block.
    class mst_scoreboard;
        logic [kea_pkg::NODE_W-1:0]  parent [kea_pkg::NODES];
        logic [kea_pkg::RANK_W-1:0]  node_rank [kea_pkg::NODES];
        logic [kea_pkg::TOTAL_W-1:0] cost_sum;
        logic [kea_pkg::COUNT_W-1:0] stations;
        logic [kea_pkg::COUNT_W-1:0] links;
        logic [kea_pkg::NODE_W-1:0]  virtual_node;
        mst_result_t                 awaited [$];
        int                          fail_count;
        int                          joins;
        int                          clears;
        int                          beats_checked;

        function new();
            wipe_forest();
            virtual_node  = '0;
            fail_count    = 0;
            joins         = 0;
            clears        = 0;
            beats_checked = 0;
        endfunction

        // Every node becomes its own root and the totals restart.
        function void wipe_forest();
            for (int i = 0; i < kea_pkg::NODES; i++)
            begin
                parent[i]    = kea_pkg::NODE_W'(i);
                node_rank[i] = kea_pkg::RANK_INIT;
            end
            cost_sum = '0;
            stations = '0;
            links    = '0;
        endfunction

        // Walks up to the root, then points every node on the path at it.
        function logic [kea_pkg::NODE_W-1:0] find_root(logic [kea_pkg::NODE_W-1:0] node);
            logic [kea_pkg::NODE_W-1:0] root;
            logic [kea_pkg::NODE_W-1:0] cur;
            logic [kea_pkg::NODE_W-1:0] nxt;
            int                         hops;
            root = node;
            hops = 0;
            while (parent[root] != root && hops < kea_pkg::NODES)
            begin
                root = parent[root];
                hops++;
            end
            cur  = node;
            hops = 0;
            while (cur != root && hops < kea_pkg::NODES)
            begin
                nxt         = parent[cur];
                parent[cur] = root;
                cur         = nxt;
                hops++;
            end
            return root;
        endfunction

        // Applies one accepted input beat and queues the output it must cause.
        function void note_item(logic op_code, logic [kea_pkg::WEIGHT_W-1:0] w,
                                logic [kea_pkg::NODE_W-1:0] a,
                                logic [kea_pkg::NODE_W-1:0] b);
            mst_result_t                res;
            logic [kea_pkg::NODE_W-1:0] ra;
            logic [kea_pkg::NODE_W-1:0] rb;
            logic [kea_pkg::TOTAL_W:0]  sum;
            res.accepted = 1'b0;
            if (op_code == kea_pkg::OP_CLEAR)
            begin
                wipe_forest();
                clears++;
            end
            else if (int'(a) < kea_pkg::NODES && int'(b) < kea_pkg::NODES)
            begin
                ra = find_root(a);
                rb = find_root(b);
                if (ra != rb)
                begin
                    res.accepted = 1'b1;
                    joins++;
                    // Union by rank; the rank only grows on a tie.
                    if (node_rank[ra] > node_rank[rb])
                        parent[rb] = ra;
                    else
                    begin
                        parent[ra] = rb;
                        if (node_rank[ra] == node_rank[rb] && node_rank[rb] < kea_pkg::RANK_MAX)
                            node_rank[rb] = node_rank[rb] + kea_pkg::RANK_W'(1);
                    end
                    // The running cost sticks at its maximum.
                    sum = {1'b0, cost_sum} + (kea_pkg::TOTAL_W + 1)'(w);
                    if (sum > {1'b0, kea_pkg::TOTAL_MAX})
                        cost_sum = kea_pkg::TOTAL_MAX;
                    else
                        cost_sum = sum[kea_pkg::TOTAL_W-1:0];
                    if (a == virtual_node || b == virtual_node)
                    begin
                        if (stations < kea_pkg::COUNT_MAX)
                            stations = stations + kea_pkg::COUNT_W'(1);
                    end
                    else if (links < kea_pkg::COUNT_MAX)
                        links = links + kea_pkg::COUNT_W'(1);
                end
            end
            res.total_cost    = cost_sum;
            res.station_count = stations;
            res.link_count    = links;
            awaited.insert(awaited.size(), res);
        endfunction

        // Compares one accepted output beat with the oldest one owed.
        function void check_result(logic acc, logic [kea_pkg::TOTAL_W-1:0] tc,
                                   logic [kea_pkg::COUNT_W-1:0] sc,
                                   logic [kea_pkg::COUNT_W-1:0] lc);
            mst_result_t want;
            if (awaited.size() == 0)
            begin
                $error("output beat with no input beat waiting for it");
                fail_count++;
                return;
            end
            want = awaited.pop_front();
            beats_checked++;
            if (acc !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, acc);
                fail_count++;
            end
            if (tc !== want.total_cost)
            begin
                $error("total_cost: expected %0d, got %0d", want.total_cost, tc);
                fail_count++;
            end
            if (sc !== want.station_count)
            begin
                $error("station_count: expected %0d, got %0d", want.station_count, sc);
                fail_count++;
            end
            if (lc !== want.link_count)
            begin
                $error("link_count: expected %0d, got %0d", want.link_count, lc);
                fail_count++;
            end
        endfunction
    endclass

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         in_valid      = 1'b0;
    logic                         in_stall;
    logic                         op            = kea_pkg::OP_EDGE;
    logic [kea_pkg::WEIGHT_W-1:0] weight        = '0;
    logic [kea_pkg::NODE_W-1:0]   node_a        = '0;
    logic [kea_pkg::NODE_W-1:0]   node_b        = '0;
    logic                         out_valid;
    logic                         out_stall     = 1'b0;
    logic                         accepted;
    logic [kea_pkg::TOTAL_W-1:0]  total_cost;
    logic [kea_pkg::COUNT_W-1:0]  station_count;
    logic [kea_pkg::COUNT_W-1:0]  link_count;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [2:0]                   paddr         = '0;
    logic [31:0]                  pwdata        = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    mst_scoreboard sb = new();
    int            idle_in_pct  = 0;
    int            stall_pct    = 0;
    int            quiet_cycles = 0;
    int            items_sent   = 0;
    int            vn_writes    = 0;

    kruskal_edge_acceptor i_dut (.*);

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver stalls at the rate of the current phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Observe both channels and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(op, weight, node_a, node_b);
            if (out_valid && !out_stall)
                sb.check_result(accepted, total_cost, station_count, link_count);
        end
    end

    // Give up when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("No beat moved for %0d cycles after %0d input beats.",
                         QUIET_LIMIT, items_sent);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [kea_pkg::WEIGHT_W-1:0] rand_weight();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[kea_pkg::WEIGHT_W-1:0];
    endfunction

    function automatic logic [kea_pkg::NODE_W-1:0] rand_node();
        return kea_pkg::NODE_W'($urandom_range(0, kea_pkg::NODES - 1));
    endfunction

    // Presents one input beat, after a random idle gap, and holds it until taken.
    task automatic send_item(input logic op_code, input logic [kea_pkg::WEIGHT_W-1:0] w,
                             input logic [kea_pkg::NODE_W-1:0] a,
                             input logic [kea_pkg::NODE_W-1:0] b);
        while ($urandom_range(0, 99) < idle_in_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_code;
        weight   <= w;
        node_a   <= a;
        node_b   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Lets every owed output beat arrive so the block is idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes virtual_node with junk in the unused upper bits, then reads it back.
    task automatic write_virtual_node(input logic [kea_pkg::NODE_W-1:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VN_ADDR;
        pwdata  <= ($urandom() & ~32'h7FF) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.virtual_node = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[kea_pkg::NODE_W-1:0] !== value)
        begin
            $error("virtual_node readback: expected %0d, got %0d", value,
                   readback[kea_pkg::NODE_W-1:0]);
            sb.fail_count++;
        end
        vn_writes++;
    endtask

    initial
    begin
        logic [kea_pkg::WEIGHT_W-1:0] last_weight;
        logic [kea_pkg::WEIGHT_W-1:0] w;
        logic [kea_pkg::NODE_W-1:0]   a;
        logic [kea_pkg::NODE_W-1:0]   b;
        logic [kea_pkg::NODE_W-1:0]   vn;
        int                           win_base;
        int                           win_span;
        int                           roll;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // The block sweeps its store after reset before it takes a beat.
        while (in_stall !== 1'b0)
            @(posedge clk);
        write_virtual_node('0);

        // Directed: clear, station and link edges, self loop, repeats, saturation.
        send_item(kea_pkg::OP_CLEAR, WEIGHT_MAX, LAST_NODE, LAST_NODE);
        send_item(kea_pkg::OP_EDGE, '0, 11'd0, 11'd1);
        send_item(kea_pkg::OP_EDGE, 62'd1, LAST_NODE, LAST_NODE - 1'b1);
        send_item(kea_pkg::OP_EDGE, 62'd2, 11'd5, 11'd5);
        send_item(kea_pkg::OP_EDGE, 62'd3, 11'd1, 11'd0);
        send_item(kea_pkg::OP_EDGE, WEIGHT_MAX, 11'd1, LAST_NODE);
        // This one lands the sum exactly on its maximum; the next one saturates.
        send_item(kea_pkg::OP_EDGE, WEIGHT_MAX, 11'd3, 11'd4);
        send_item(kea_pkg::OP_EDGE, 62'd5, 11'd5, 11'd6);
        send_item(kea_pkg::OP_EDGE, 62'd2, 11'd7, 11'd8);
        send_item(kea_pkg::OP_EDGE, 62'd10, 11'd4, LAST_NODE - 1'b1);
        send_item(kea_pkg::OP_EDGE, 62'd11, 11'd3, 11'd0);
        send_item(kea_pkg::OP_EDGE, 62'd12, 11'd8, 11'd6);
        send_item(kea_pkg::OP_CLEAR, '0, '0, '0);
        send_item(kea_pkg::OP_EDGE, '0, LAST_NODE, 11'd0);
        wait_drained();
        write_virtual_node(LAST_NODE);
        send_item(kea_pkg::OP_EDGE, 62'd1, LAST_NODE, 11'd0);
        send_item(kea_pkg::OP_EDGE, 62'd2, 11'd10, LAST_NODE);
        send_item(kea_pkg::OP_EDGE, 62'd3, 11'd0, 11'd1);
        send_item(kea_pkg::OP_EDGE, WEIGHT_MAX, LAST_NODE - 1'b1, LAST_NODE - 2'd2);

        // Random phases: sorted edges inside a node window, plus noise and clears.
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_drained();
            case (phase % 4)
                0: begin idle_in_pct = 0;  stall_pct = 0;  end
                1: begin idle_in_pct = 57; stall_pct = 0;  end
                2: begin idle_in_pct = 0;  stall_pct = 57; end
                default: begin idle_in_pct = 26; stall_pct = 26; end
            endcase
            case (phase % 4)
                0: win_span = 16;
                1: win_span = 64;
                2: win_span = 256;
                default: win_span = kea_pkg::NODES;
            endcase
            win_base = $urandom_range(0, kea_pkg::NODES - win_span);
            if (phase == 0)
                vn = '0;
            else if (phase == 1)
            begin
                vn       = LAST_NODE;
                win_base = kea_pkg::NODES - win_span;
            end
            else
                vn = kea_pkg::NODE_W'(win_base + $urandom_range(0, win_span - 1));
            write_virtual_node(vn);
            send_item(kea_pkg::OP_CLEAR, rand_weight(), rand_node(), rand_node());
            last_weight = '0;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 999);
                if (roll < 8)
                    send_item(kea_pkg::OP_CLEAR, rand_weight(), rand_node(), rand_node());
                else if (roll < 150)
                begin
                    // Noise: any endpoints, mostly small unsorted weights.
                    if ($urandom_range(0, 99) < 5)
                        w = rand_weight();
                    else
                        w = kea_pkg::WEIGHT_W'($urandom());
                    send_item(kea_pkg::OP_EDGE, w, rand_node(), rand_node());
                end
                else
                begin
                    a = kea_pkg::NODE_W'(win_base + $urandom_range(0, win_span - 1));
                    if ($urandom_range(0, 99) < 10)
                        b = vn;
                    else
                        b = kea_pkg::NODE_W'(win_base + $urandom_range(0, win_span - 1));
                    if ($urandom_range(0, 99) < 2)
                        w = WEIGHT_MAX - kea_pkg::WEIGHT_W'($urandom_range(0, 15));
                    else if (last_weight > WEIGHT_MAX - 62'd4096)
                        w = WEIGHT_MAX;
                    else
                        w = last_weight + kea_pkg::WEIGHT_W'($urandom_range(0, 4095));
                    last_weight = w;
                    if ($urandom_range(0, 1) == 1)
                        send_item(kea_pkg::OP_EDGE, w, a, b);
                    else
                        send_item(kea_pkg::OP_EDGE, w, b, a);
                end
            end
        end

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Sent %0d input beats, checked %0d output beats, %0d joins, %0d clears.",
                 items_sent, sb.beats_checked, sb.joins, sb.clears);
        $display("Used %0d virtual_node settings across %0d idle and stall phases.",
                 vn_writes, RAND_PHASES);
        if (sb.fail_count == 0 && sb.awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* kruskal_edge_acceptor.f */
design/kea_pkg.sv
design/kea_ram.sv
design/kruskal_edge_acceptor.sv
tb/tb_kruskal_edge_acceptor.sv
